FILE: hdl/gbn_pkg.sv
`timescale 1ns / 1ps
// Package for the Go-Back-N sender: sequence constants, operation codes,
// FSM states and the payload store request struct. No dependencies.
package gbn_pkg;

	localparam int SEQ_W = 3;
	localparam int SEQ_SPACE = 1 << SEQ_W;
	localparam int WIN_W = 3;
	localparam logic [WIN_W-1:0] WINDOW_RESET = 3'd3;
	// At most SEQ_SPACE - 1 packets may be in flight.
	localparam logic [SEQ_W-1:0] SEQ_LIMIT = SEQ_W'(SEQ_SPACE - 1);

	typedef logic [SEQ_W-1:0] seq_t;

	typedef enum logic [1:0] {
		OP_SEND    = 2'd0,
		OP_ACK     = 2'd1,
		OP_TIMEOUT = 2'd2
	} op_t;

	typedef enum logic {
		ST_IDLE   = 1'b0,
		ST_RESEND = 1'b1
	} state_t;

	typedef struct packed {
		logic wr_en;
		seq_t wr_addr;
		seq_t rd_addr;
	} store_req_t;

endpackage

FILE: hdl/gbn_store.sv
`timescale 1ns / 1ps
// Payload store of the Go-Back-N sender: one entry per sequence number,
// one write port and one registered read port. Depends on gbn_pkg.
module gbn_store #(
	parameter int DATA_W = 64
) (
	input  logic                 clk,
	input  gbn_pkg::store_req_t  req,
	input  logic [DATA_W-1:0]    wr_data,
	output logic [DATA_W-1:0]    rd_data
);

	logic [DATA_W-1:0] mem [gbn_pkg::SEQ_SPACE];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= wr_data;
		end
	end

	// Read data is registered and shows up in the cycle after the address.
	always_ff @(posedge clk) begin
		rd_data_q <= mem[req.rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

FILE: hdl/go_back_n_sender.sv
`timescale 1ns / 1ps
// Top level of the Go-Back-N ARQ sender: window bookkeeping, command FSM
// and result register. Depends on gbn_pkg and gbn_store.
//
// Channel   Direction  Handshake                  Payload
// command   in         start, busy                operation, payload, ack_number,
//                                                 ack_checksum_ok, expired_seq
// config    in         cfg_valid, cfg_ready       cfg_data (window_size)
// result    out        result_valid (strobe)      accepted, tx_valid, tx_seq,
//                                                 tx_payload, timer_stop(_seq),
//                                                 timer_start(_seq), last
//
// A send, an ack, an unknown operation or a timeout with nothing in flight
// gives a single result, which appears in the cycle after the transfer.
// A timeout with packets in flight holds busy while the store is read
// one entry per cycle through its single read port, and the next command
// can be taken once busy drops. Reset clears the window (base and count)
// and sets window_size to 3; the payload store is not cleared.
// Results are strobed for one cycle and cannot be held off by the receiver.
module go_back_n_sender #(
	parameter int PAYLOAD_BITS = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// Command channel.
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              operation,
	input  logic [PAYLOAD_BITS-1:0] payload,
	input  logic [2:0]              ack_number,
	input  logic                    ack_checksum_ok,
	input  logic [2:0]              expired_seq,
	// Configuration channel.
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [2:0]              cfg_data,
	// Result channel.
	output logic                    result_valid,
	output logic                    accepted,
	output logic                    tx_valid,
	output logic [2:0]              tx_seq,
	output logic [PAYLOAD_BITS-1:0] tx_payload,
	output logic                    timer_stop,
	output logic [2:0]              timer_stop_seq,
	output logic                    timer_start,
	output logic [2:0]              timer_start_seq,
	output logic                    last
);

	gbn_pkg::state_t state_q, state_d;

	// Window state: oldest unacknowledged sequence number and the count.
	gbn_pkg::seq_t              base_q, base_d;
	logic [gbn_pkg::WIN_W-1:0]  outst_q, outst_d;
	logic [gbn_pkg::WIN_W-1:0]  window_q;

	// Resend walk: index into the window, packets to resend, expired timer.
	gbn_pkg::seq_t              idx_q, idx_d;
	logic [gbn_pkg::WIN_W-1:0]  cnt_q, cnt_d;
	gbn_pkg::seq_t              exp_q, exp_d;

	gbn_pkg::store_req_t        store_req;
	logic [PAYLOAD_BITS-1:0]    rd_data;

	// Next values of the result register.
	logic                    load_res;
	logic                    acc_d, txv_d, stop_d, sta_d, last_d;
	gbn_pkg::seq_t           txs_d, stops_d, stas_d;
	logic [PAYLOAD_BITS-1:0] txp_d;

	logic                    take;
	logic                    resend_last;
	gbn_pkg::seq_t           send_seq;
	gbn_pkg::seq_t           ack_off;
	logic                    win_full;

	assign busy      = (state_q == gbn_pkg::ST_RESEND);
	assign cfg_ready = 1'b1;
	assign take      = start && !busy;

	assign send_seq    = base_q + gbn_pkg::seq_t'(outst_q);
	assign ack_off     = ack_number - base_q;
	assign win_full    = (outst_q >= window_q) || (outst_q >= gbn_pkg::SEQ_LIMIT);
	assign resend_last = (idx_q == gbn_pkg::seq_t'(cnt_q - 1'b1));

	gbn_store #(
		.DATA_W (PAYLOAD_BITS)
	) u_store (
		.clk     (clk),
		.req     (store_req),
		.wr_data (payload),
		.rd_data (rd_data)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gbn_pkg::ST_IDLE: begin
				if (take && (gbn_pkg::op_t'(operation) == gbn_pkg::OP_TIMEOUT) &&
				    (outst_q != '0)) begin
					state_d = gbn_pkg::ST_RESEND;
				end
			end
			gbn_pkg::ST_RESEND: begin
				if (resend_last) begin
					state_d = gbn_pkg::ST_IDLE;
				end
			end
			default: state_d = gbn_pkg::ST_IDLE;
		endcase
	end

	// Datapath and result values.
	always_comb begin
		load_res  = 1'b0;
		acc_d     = 1'b0;
		txv_d     = 1'b0;
		txs_d     = '0;
		txp_d     = '0;
		stop_d    = 1'b0;
		stops_d   = '0;
		sta_d     = 1'b0;
		stas_d    = '0;
		last_d    = 1'b0;
		base_d    = base_q;
		outst_d   = outst_q;
		idx_d     = idx_q;
		cnt_d     = cnt_q;
		exp_d     = exp_q;
		store_req = '{wr_en: 1'b0, wr_addr: send_seq, rd_addr: base_q};

		unique case (state_q)
			gbn_pkg::ST_IDLE: begin
				if (take) begin
					load_res = 1'b1;
					last_d   = 1'b1;
					case (gbn_pkg::op_t'(operation))
						gbn_pkg::OP_SEND: begin
							if (!win_full) begin
								store_req.wr_en = 1'b1;
								outst_d = outst_q + 1'b1;
								acc_d   = 1'b1;
								txv_d   = 1'b1;
								txs_d   = send_seq;
								txp_d   = payload;
								if (outst_q == '0) begin
									sta_d  = 1'b1;
									stas_d = send_seq;
								end
							end
						end
						gbn_pkg::OP_ACK: begin
							// A cumulative ack frees everything up to and
							// including the named packet.
							if (ack_checksum_ok && (outst_q != '0) &&
							    (gbn_pkg::WIN_W'(ack_off) < outst_q)) begin
								base_d  = ack_number + 1'b1;
								outst_d = outst_q - gbn_pkg::WIN_W'(ack_off) - 1'b1;
								stop_d  = 1'b1;
								stops_d = ack_number;
								if (outst_d != '0) begin
									sta_d  = 1'b1;
									stas_d = base_d;
								end
							end
						end
						gbn_pkg::OP_TIMEOUT: begin
							if (outst_q == '0) begin
								stop_d  = 1'b1;
								stops_d = expired_seq;
							end else begin
								// Start the walk; the first read is issued now.
								load_res = 1'b0;
								idx_d    = '0;
								cnt_d    = outst_q;
								exp_d    = expired_seq;
							end
						end
						default: begin
						end
					endcase
				end
			end
			gbn_pkg::ST_RESEND: begin
				load_res = 1'b1;
				txv_d    = 1'b1;
				txs_d    = base_q + idx_q;
				txp_d    = rd_data;
				last_d   = resend_last;
				if (idx_q == '0) begin
					stop_d  = 1'b1;
					stops_d = exp_q;
					sta_d   = 1'b1;
					stas_d  = base_q;
				end
				store_req.rd_addr = base_q + idx_q + 1'b1;
				idx_d = idx_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= gbn_pkg::ST_IDLE;
			base_q       <= '0;
			outst_q      <= '0;
			window_q     <= gbn_pkg::WINDOW_RESET;
			idx_q        <= '0;
			cnt_q        <= '0;
			exp_q        <= '0;
			result_valid <= 1'b0;
		end else begin
			state_q      <= state_d;
			base_q       <= base_d;
			outst_q      <= outst_d;
			idx_q        <= idx_d;
			cnt_q        <= cnt_d;
			exp_q        <= exp_d;
			result_valid <= load_res;
			if (cfg_valid && cfg_ready) begin
				window_q <= cfg_data;
			end
		end
	end

	// Result payload register; qualified by result_valid.
	always_ff @(posedge clk) begin
		if (load_res) begin
			accepted        <= acc_d;
			tx_valid        <= txv_d;
			tx_seq          <= txs_d;
			tx_payload      <= txp_d;
			timer_stop      <= stop_d;
			timer_stop_seq  <= stops_d;
			timer_start     <= sta_d;
			timer_start_seq <= stas_d;
			last            <= last_d;
		end
	end

endmodule
